// ===== hw/rtl/fir8_scaled_filter_top_macros.svh =====
// Assertion helpers for the filter top level.
`ifndef FIR8_SCALED_FILTER_TOP_MACROS_SVH
`define FIR8_SCALED_FILTER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define F8SF_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("f8sf assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define F8SF_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("f8sf assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/f8sf_pkg.sv =====
package f8sf_pkg;

  // Sample and coefficient width
  localparam int unsigned SMP_W         = 16;
  // Full product width of two samples
  localparam int unsigned PROD_W        = 32;
  // Coefficient registers, always all stored
  localparam int unsigned NUM_COEFS     = 8;
  localparam int unsigned COEF_IDX_W    = $clog2(NUM_COEFS);
  localparam int unsigned CFG_IDX_W     = 4;
  // Default and maximum tap count
  localparam int unsigned TAPS_DEF      = 8;
  // Divisor is SCALE_PER_TAP * TAPS
  localparam int unsigned SCALE_PER_TAP = 10;

  // Reciprocal divide: magnitude is halved first, then multiplied by
  // ceil(2^RECIP_SHIFT / (divisor/2)); exact for all magnitudes up to 2^30.
  localparam int unsigned HALF_W        = 30;
  localparam int unsigned RECIP_W       = 33;
  localparam int unsigned RECIP_SHIFT   = 35;
  localparam int unsigned RP_W          = HALF_W + RECIP_W;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef smp_t [NUM_COEFS-1:0] coef_arr_t;

  // Per-cycle load enables handed to every tap cell
  typedef struct packed {
    logic shift;  // a sample beat is accepted: advance the delay line
    logic en1;    // product stage loads
    logic en2;    // reciprocal stage loads
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/f8sf_in_if.sv =====
interface f8sf_in_if;
  logic           valid;
  logic           ready;
  f8sf_pkg::smp_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ===== hw/rtl/f8sf_out_if.sv =====
interface f8sf_out_if;
  logic           valid;
  logic           ready;
  f8sf_pkg::smp_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== hw/rtl/f8sf_cfg_if.sv =====
interface f8sf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [f8sf_pkg::CFG_IDX_W-1:0]   index;
  logic [f8sf_pkg::SMP_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/f8sf_coef_bank.sv =====
module f8sf_coef_bank (
  input  logic                clk,
  input  logic                rst,
  f8sf_cfg_if.sink            cfg,
  output f8sf_pkg::coef_arr_t coef
);
  import f8sf_pkg::*;

  logic wr_hit;

  // Always take write beats; drop those beyond the register list
  assign cfg.ready = 1'b1;
  assign wr_hit    = cfg.valid && (cfg.index < CFG_IDX_W'(NUM_COEFS));

  // Hold coefficients, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr_hit) begin
      coef[cfg.index[COEF_IDX_W-1:0]] <= smp_t'(cfg.data);
    end
  end

endmodule

// ===== hw/rtl/f8sf_tap_cell.sv =====
module f8sf_tap_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned Taps = f8sf_pkg::TAPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  f8sf_pkg::pipe_ctl_t               ctl,
  input  logic signed [f8sf_pkg::SMP_W-1:0] coef,
  input  logic signed [f8sf_pkg::SMP_W-1:0] x_in,
  output logic signed [f8sf_pkg::SMP_W-1:0] x_tap,
  input  logic        [f8sf_pkg::SMP_W-1:0] sum_in,
  output logic        [f8sf_pkg::SMP_W-1:0] sum_out
);
  import f8sf_pkg::*;

  localparam int unsigned HalfDiv = Taps * SCALE_PER_TAP / 2;
  localparam logic [RECIP_W-1:0] Recip =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(HalfDiv) - 64'd1) / 64'(HalfDiv));

  logic signed [PROD_W-1:0] prod;
  logic                     neg;
  logic        [PROD_W-1:0] mag;
  logic        [HALF_W-1:0] half;
  logic        [RP_W-1:0]   rp;
  logic                     neg2;
  logic        [SMP_W-1:0]  quo;
  logic        [SMP_W-1:0]  quo_s;

  // Tap sample: the live input for the first cell, a delay stage otherwise
  generate
    if (Idx == 0) begin : g_live
      assign x_tap = x_in;
    end else begin : g_dly
      logic signed [SMP_W-1:0] dly;

      // Advance one sample per accepted beat, cleared at reset
      always_ff @(posedge clk) begin
        if (rst) begin
          dly <= '0;
        end else if (ctl.shift) begin
          dly <= x_in;
        end
      end
      assign x_tap = dly;
    end
  endgenerate

  // Stage 1: exact signed product
  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      prod <= PROD_W'(coef) * PROD_W'(x_tap);
    end
  end

  // Magnitude, halved since the divisor is even
  assign neg  = prod[PROD_W-1];
  assign mag  = neg ? (-prod) : prod;
  assign half = mag[HALF_W:1];

  // Stage 2: divide the magnitude by reciprocal multiply
  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      rp   <= RP_W'(half) * RP_W'(Recip);
      neg2 <= neg;
    end
  end

  // Restore sign (truncation toward zero) and add into the running sum
  assign quo     = rp[RECIP_SHIFT +: SMP_W];
  assign quo_s   = neg2 ? (-quo) : quo;
  assign sum_out = sum_in + quo_s;

endmodule

// ===== hw/rtl/fir8_scaled_filter_top.sv =====
// Streaming FIR filter on signed 16-bit samples: every sample beat yields
// one filtered beat, sum over taps k of (coef_tapk * x[n-k]) / (10 * TAPS),
// each quotient truncated toward zero and the sum wrapped to 16 bits. It
// takes one sample per clock while the pipe can move; the edge that accepts
// a sample loads the product register, then the reciprocal-divide register
// and the output register load in turn, and each stage
// holds or collapses bubbles on its own, so a stalled output only blocks
// the input once the pipe is full. TAPS (1 to 8)
// sets the number of tap cells and the divisor; all eight coefficient
// registers are stored regardless. Coefficients reset to zero and the delay
// line starts from zeros; write coefficients only while the pipe is empty.
// Writes to an index of 8 or above are ignored.
`include "fir8_scaled_filter_top_macros.svh"

module fir8_scaled_filter_top #(
  parameter int unsigned TAPS = f8sf_pkg::TAPS_DEF
) (
  input logic        clk,
  input logic        rst,
  f8sf_in_if.sink    in_ch,
  f8sf_out_if.source out_ch,
  f8sf_cfg_if.sink   cfg
);
  import f8sf_pkg::*;

  coef_arr_t        coef;
  pipe_ctl_t        ctl;
  logic             v1;
  logic             v2;
  logic             en3;
  smp_t             x_tap [TAPS];
  logic [SMP_W-1:0] sum_chain [TAPS+1];

  // Coefficient registers
  f8sf_coef_bank u_coef_bank (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .coef (coef)
  );

  // Per-stage flow: a stage loads when it is empty or its content moves on
  assign en3           = !out_ch.valid || out_ch.ready;
  assign ctl.en2       = !v2 || en3;
  assign ctl.en1       = !v1 || ctl.en2;
  assign in_ch.ready   = ctl.en1;
  assign ctl.shift     = in_ch.valid && ctl.en1;

  // Row of tap cells; samples and partial sums pass along the row
  assign sum_chain[0] = '0;
  generate
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
      smp_t x_in;
      if (k == 0) begin : g_first
        assign x_in = in_ch.sample_in;
      end else begin : g_next
        assign x_in = x_tap[k-1];
      end

      f8sf_tap_cell #(
        .Idx  (k),
        .Taps (TAPS)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .coef    (coef[k]),
        .x_in    (x_in),
        .x_tap   (x_tap[k]),
        .sum_in  (sum_chain[k]),
        .sum_out (sum_chain[k+1])
      );
    end
  endgenerate

  // Stage valids and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (ctl.en1) begin
        v1 <= in_ch.valid;
      end
      if (ctl.en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_ch.valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_ch.sample_out <= smp_t'(sum_chain[TAPS]);
    end
  end

  `F8SF_ASSERT_IMPL(a_stall_needs_full_s1, clk, rst, !in_ch.ready, v1)
  `F8SF_ASSERT_NEXT(a_accept_fills_s1, clk, rst, in_ch.valid && in_ch.ready, v1)
  `F8SF_ASSERT_IMPL(a_out_from_s2, clk, rst, $rose(out_ch.valid), $past(v2))
  `F8SF_ASSERT_NEXT(a_s2_moves_out, clk, rst, v2 && en3, out_ch.valid)

endmodule

// ===== tb/fir8_scaled_filter_checker.sv =====
`timescale 1ns / 1ps

module fir8_scaled_filter_checker
  import f8sf_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  input  logic                 sample_ready,
  input  smp_t                 sample_in,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  smp_t                 sample_out,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SMP_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam int HISTORY_DEPTH = 7;
  // Keep the divisor signed so the quotient truncates toward zero
  localparam int SCALE_DIV = int'(TAPS * SCALE_PER_TAP);

  smp_t coef [NUM_COEFS];
  smp_t history [HISTORY_DEPTH];
  smp_t filtered_q [$];

  // Sum of scaled tap products, wrapped to 16 bits
  function automatic smp_t filtered_sample(input smp_t x);
    int          k;
    int          prod;
    logic [15:0] acc;
    smp_t        tap_val;
    acc = '0;
    for (k = 0; k < int'(TAPS); k++) begin
      tap_val = (k == 0) ? x : history[k-1];
      prod = int'(coef[k]) * int'(tap_val);
      acc = acc + 16'(prod / SCALE_DIV);
    end
    return smp_t'(acc);
  endfunction

  // Track coefficients and history, queue predictions, compare results
  always @(posedge clk) begin
    int   k;
    smp_t want;
    if (rst) begin
      foreach (coef[i]) coef[i] = '0;
      foreach (history[i]) history[i] = '0;
      filtered_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_COEFS) begin
        coef[cfg_index[COEF_IDX_W-1:0]] = cfg_data;
      end
      if (sample_valid && sample_ready) begin
        filtered_q.push_back(filtered_sample(sample_in));
        for (k = HISTORY_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = sample_in;
      end
      if (result_valid && result_ready) begin
        if (filtered_q.size() == 0) begin
          $error("sample_out: beat with nothing pending, expected none, actual %0d",
                 sample_out);
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          if (sample_out !== want) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want, sample_out);
            fail_count++;
          end
        end
      end
    end
    outstanding = filtered_q.size();
  end

endmodule

// ===== tb/fir8_scaled_filter_top_tb.sv =====
`timescale 1ns / 1ps

module fir8_scaled_filter_top_tb;
  import f8sf_pkg::*;

  localparam int unsigned COEF_TAP0_IDX = 0;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned HOLD_AT       = 300;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS   = 155;
  localparam int unsigned DRAIN_CYCLES  = 10;

  typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_e;
  typedef enum int {MIX_FULL, MIX_EXTREME, MIX_SMALL, MIX_SAMPLE} coef_mix_e;

  localparam smp_t EDGE_SAMPLES [16] = '{
    16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'd79,
    -16'sd79, 16'd80, -16'sd80, 16'h5555, 16'hAAAA, 16'd100, -16'sd100, 16'h7FFF
  };
  localparam smp_t EDGE_COEFS [8] = '{
    16'h0000, 16'h8000, 16'h7FFF, 16'd1, 16'hFFFF, 16'd80, -16'sd80, 16'd79
  };

  logic     clk;
  logic     rst;
  int       fail_count;
  int       outstanding;
  int       samples_sent = 0;
  int       burst_left;
  int       hold_left;
  int       seg_left;
  bit       hold_done;
  rx_mode_e rx_mode;

  f8sf_in_if  sample_ch ();
  f8sf_out_if result_ch ();
  f8sf_cfg_if cfg_ch ();

  fir8_scaled_filter_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (sample_ch),
    .out_ch (result_ch),
    .cfg    (cfg_ch)
  );

  fir8_scaled_filter_checker chk (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_ch.valid),
    .sample_ready (sample_ch.ready),
    .sample_in    (sample_ch.sample_in),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .sample_out   (result_ch.sample_out),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Count accepted sample beats for the long hold-off trigger
  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready) samples_sent <= samples_sent + 1;
  end

  function automatic smp_t random_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return smp_t'(int'($urandom_range(0, 200)) - 100);
      default: return smp_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
    end
  endtask

  // Offer one sample beat, then advance the burst pattern
  task automatic send_sample(input smp_t s);
    @(negedge clk);
    sample_ch.valid     <= 1'b1;
    sample_ch.sample_in <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_sender($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 16);
    end
  endtask

  task automatic write_reg(input int unsigned idx, input smp_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx[CFG_IDX_W-1:0];
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering and wait until every filtered beat has come back
  task automatic drain();
    idle_sender(1);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Receiver: segments of streaming, random and sparse ready, plus one long hold
  initial begin
    result_ch.ready = 1'b0;
    hold_left = 0;
    seg_left  = 0;
    hold_done = 1'b0;
    rx_mode   = RX_STREAM;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && samples_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        result_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = rx_mode_e'($urandom_range(0, 2));
          seg_left = $urandom_range(8, 60);
        end
        seg_left--;
        case (rx_mode)
          RX_STREAM: result_ch.ready <= 1'b1;
          RX_RANDOM: result_ch.ready <= 1'($urandom_range(0, 1));
          default:   result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    int        p;
    int        k;
    coef_mix_e mix;
    smp_t      c;
    rst                 = 1'b1;
    sample_ch.valid     = 1'b0;
    sample_ch.sample_in = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    burst_left          = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Tap 0 left at its reset value; history starts from zeros
    for (k = 1; k < NUM_COEFS; k++) write_reg(COEF_TAP0_IDX + k, EDGE_COEFS[k]);
    for (k = NUM_COEFS; k < 16; k++) begin
      write_reg(k, (k % 2 == 0) ? 16'h7FFF : 16'h8000);
    end
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
    drain();

    // All taps at the negative extreme, largest products
    for (k = 0; k < NUM_COEFS; k++) write_reg(COEF_TAP0_IDX + k, 16'h8000);
    repeat (7) send_sample(16'h8000);
    repeat (3) send_sample(16'h7FFF);
    drain();

    // Random phases, each with its own coefficient set
    for (p = 0; p < RAND_PHASES; p++) begin
      mix = coef_mix_e'(p % 4);
      for (k = 0; k < NUM_COEFS; k++) begin
        case (mix)
          MIX_FULL:    c = smp_t'($urandom_range(0, 16'hFFFF));
          MIX_EXTREME: c = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          MIX_SMALL:   c = smp_t'(int'($urandom_range(0, 400)) - 200);
          default:     c = random_sample();
        endcase
        write_reg(COEF_TAP0_IDX + k, c);
      end
      write_reg($urandom_range(NUM_COEFS, 15), smp_t'($urandom_range(0, 16'hFFFF)));
      repeat (PHASE_ITEMS) send_sample(random_sample());
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/f8sf_pkg.sv
hw/rtl/f8sf_in_if.sv
hw/rtl/f8sf_out_if.sv
hw/rtl/f8sf_cfg_if.sv
hw/rtl/f8sf_coef_bank.sv
hw/rtl/f8sf_tap_cell.sv
hw/rtl/fir8_scaled_filter_top.sv
tb/fir8_scaled_filter_checker.sv
tb/fir8_scaled_filter_top_tb.sv
